// File: design/scc_pkg.sv
// Shared types and constants for the sphere-sphere contact pipeline.
// Used by every module of the block; depends on nothing.
package scc_pkg;

    localparam int IN_W     = 256;  // slave tdata width
    localparam int OUT_W    = 176;  // master tdata width
    localparam int ROOT_W   = 32;   // bits of the integer square root
    localparam int QUO_W    = 31;   // quotient bits of each divider lane
    localparam int NUM_W    = 63;   // divider numerator width
    localparam int DEN_W    = 33;   // divider denominator width
    localparam logic [15:0] NORMAL_ONE = 16'd16384;
    localparam logic [15:0] NZ_RESET   = 16'd7;

    // item data carried alongside the distance computation
    typedef struct packed {
        logic [2:0][31:0] a;     // centre of A
        logic [2:0][30:0] dmag;  // |B - A| per axis
        logic [2:0]       dneg;  // sign of B - A per axis
        logic [29:0]      ra;
        logic [29:0]      rb;
        logic             miss;  // far component seen
    } t_side_front;

    // item data carried alongside the divider lanes
    typedef struct packed {
        logic [2:0][31:0] a;
        logic [2:0]       dneg;
        logic             fneg;  // sign of (ra - rb + dist)
        logic [30:0]      pen;
        logic             hit;
        logic             coinc; // centres nearly coincident
    } t_side_div;

endpackage

// File: design/scc_front.sv
// Front end: centre offsets, far-component test, squares and their sum.
// Four register stages. Depends on scc_pkg.
module scc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [2:0][31:0]          i_a,
    input  logic [2:0][31:0]          i_b,
    input  logic [29:0]               i_ra,
    input  logic [29:0]               i_rb,
    output logic                      o_valid,
    output logic [63:0]               o_sum,
    output scc_pkg::t_side_front      o_side
);
    import scc_pkg::*;

    logic [3:0]       r_vld;
    logic [2:0][32:0] r1_d;
    logic [2:0][31:0] r1_a;
    logic [30:0]      r1_rsum;
    logic [29:0]      r1_ra, r1_rb;
    t_side_front      r2_side, r3_side, r4_side;
    logic [2:0][61:0] r3_sq;
    logic [63:0]      r4_sum;
    logic [2:0][32:0] n_mag;
    logic             n_far;

    // offset magnitudes and the far test
    always_comb begin
        n_far = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r1_d[i][32] ? (~r1_d[i] + 33'd1) : r1_d[i];
            if (n_mag[i] > {2'b00, r1_rsum}) n_far = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: offsets B - A, radius sum
            for (int i = 0; i < 3; i++) begin
                r1_d[i] <= {i_b[i][31], i_b[i]} - {i_a[i][31], i_a[i]};
            end
            r1_a    <= i_a;
            r1_rsum <= {1'b0, i_ra} + {1'b0, i_rb};
            r1_ra   <= i_ra;
            r1_rb   <= i_rb;
            // stage 2: magnitudes
            for (int i = 0; i < 3; i++) begin
                r2_side.dmag[i] <= n_mag[i][30:0];
                r2_side.dneg[i] <= r1_d[i][32];
            end
            r2_side.a    <= r1_a;
            r2_side.ra   <= r1_ra;
            r2_side.rb   <= r1_rb;
            r2_side.miss <= n_far;
            // stage 3: squares
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= r2_side.dmag[i] * r2_side.dmag[i];
            end
            r3_side <= r2_side;
            // stage 4: sum of squares
            r4_sum  <= {2'b00, r3_sq[0]} + {2'b00, r3_sq[1]} + {2'b00, r3_sq[2]};
            r4_side <= r3_side;
        end
    end

    assign o_valid = r_vld[3];
    assign o_sum   = r4_sum;
    assign o_side  = r4_side;

endmodule

// File: design/scc_root.sv
// Integer square root, one result bit per register stage (32 stages).
// Depends on scc_pkg.
module scc_root (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [63:0]               i_sum,
    input  scc_pkg::t_side_front      i_side,
    output logic                      o_valid,
    output logic [scc_pkg::ROOT_W-1:0] o_dist,
    output scc_pkg::t_side_front      o_side
);
    import scc_pkg::*;

    logic [63:0]       r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    t_side_front       r_side [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_vld;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int K = ROOT_W - 1 - j;
        logic [63:0]       p_rem;
        logic [ROOT_W-1:0] p_root;
        t_side_front       p_side;
        logic              p_vld;
        logic [63:0]       trial;

        if (j == 0) begin : g_first
            assign p_rem  = i_sum;
            assign p_root = '0;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[j-1];
            assign p_root = r_root[j-1];
            assign p_side = r_side[j-1];
            assign p_vld  = r_vld[j-1];
        end

        // (root + 2^K)^2 - root^2
        assign trial = ({{(64-ROOT_W){1'b0}}, p_root} << (K + 1)) + (64'd1 << (2 * K));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= p_side;
                if (p_rem >= trial) begin
                    r_rem[j]  <= p_rem - trial;
                    r_root[j] <= p_root | (ROOT_W'(1) << K);
                end else begin
                    r_rem[j]  <= p_rem;
                    r_root[j] <= p_root;
                end
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_dist  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// File: design/scc_prep.sv
// Penetration, coincidence test and divider operands (four stages).
// Depends on scc_pkg.
module scc_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [scc_pkg::ROOT_W-1:0]    i_dist,
    input  scc_pkg::t_side_front          i_side,
    input  logic [15:0]                   i_nz,
    output logic                          o_valid,
    output scc_pkg::t_side_div            o_side,
    output logic [2:0][scc_pkg::NUM_W-1:0] o_num_n,
    output logic [2:0][scc_pkg::NUM_W-1:0] o_num_o,
    output logic [scc_pkg::DEN_W-1:0]     o_den_n,
    output logic [scc_pkg::DEN_W-1:0]     o_den_o
);
    import scc_pkg::*;

    logic [3:0]              r_vld;
    // stage 1
    logic [33:0]             r1_pen, r1_fac;
    logic                    r1_miss, r1_coinc;
    logic [ROOT_W-1:0]       r1_dist;
    t_side_front             r1_sf;
    // stage 2
    t_side_div               r2_side;
    logic [2:0][30:0]        r2_dmag;
    logic [31:0]             r2_fmag;
    logic [2:0][NUM_W-1:0]   r2_nnum;
    logic [ROOT_W-1:0]       r2_dist;
    // stage 3
    t_side_div               r3_side;
    logic [2:0][NUM_W-1:0]   r3_prod, r3_nnum;
    logic [ROOT_W-1:0]       r3_dist;
    // stage 4
    t_side_div               r4_side;
    logic [2:0][NUM_W-1:0]   r4_onum, r4_nnum;
    logic [ROOT_W-1:0]       r4_dist;
    logic [33:0]             n_fmag;

    assign n_fmag = r1_fac[33] ? (~r1_fac + 34'd1) : r1_fac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: pen = ra + rb - dist, factor = ra - rb + dist
            r1_pen   <= {4'd0, i_side.ra} + {4'd0, i_side.rb} - {2'b00, i_dist};
            r1_fac   <= {4'd0, i_side.ra} - {4'd0, i_side.rb} + {2'b00, i_dist};
            r1_miss  <= i_side.miss;
            r1_coinc <= (i_dist == '0) || (i_dist < {16'd0, i_nz});
            r1_dist  <= i_dist;
            r1_sf    <= i_side;
            // stage 2: factor magnitude, normal numerators (rounding half added)
            r2_side.a     <= r1_sf.a;
            r2_side.dneg  <= r1_sf.dneg;
            r2_side.fneg  <= r1_fac[33];
            r2_side.pen   <= r1_pen[30:0];
            r2_side.hit   <= !r1_miss && !r1_pen[33];
            r2_side.coinc <= r1_coinc;
            r2_dmag       <= r1_sf.dmag;
            r2_fmag       <= n_fmag[31:0];
            for (int i = 0; i < 3; i++) begin
                r2_nnum[i] <= {18'd0, r1_sf.dmag[i], 14'd0} +
                              {32'd0, r1_dist[ROOT_W-1:1]};
            end
            r2_dist <= r1_dist;
            // stage 3: offset products
            for (int i = 0; i < 3; i++) begin
                r3_prod[i] <= r2_dmag[i] * r2_fmag;
            end
            r3_nnum <= r2_nnum;
            r3_side <= r2_side;
            r3_dist <= r2_dist;
            // stage 4: offset numerators, half of 2*dist added for rounding
            for (int i = 0; i < 3; i++) begin
                r4_onum[i] <= r3_prod[i] + {31'd0, r3_dist};
            end
            r4_nnum <= r3_nnum;
            r4_side <= r3_side;
            r4_dist <= r3_dist;
        end
    end

    assign o_valid = r_vld[3];
    assign o_side  = r4_side;
    assign o_num_n = r4_nnum;
    assign o_num_o = r4_onum;
    assign o_den_n = {1'b0, r4_dist};
    assign o_den_o = {r4_dist, 1'b0};

endmodule

// File: design/scc_div.sv
// Unsigned restoring divider lane, one quotient bit per register stage.
// The quotient is known to fit QUO_W bits. Depends on scc_pkg.
module scc_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [scc_pkg::NUM_W-1:0]   i_num,
    input  logic [scc_pkg::DEN_W-1:0]   i_den,
    output logic [scc_pkg::QUO_W-1:0]   o_quo
);
    import scc_pkg::*;

    logic [63:0]      r_rem [0:QUO_W-1];
    logic [DEN_W-1:0] r_den [0:QUO_W-1];
    logic [QUO_W-1:0] r_quo [0:QUO_W-1];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int K = QUO_W - 1 - j;
        logic [63:0]      p_rem;
        logic [DEN_W-1:0] p_den;
        logic [QUO_W-1:0] p_quo;
        logic [63:0]      shifted;

        if (j == 0) begin : g_first
            assign p_rem = {1'b0, i_num};
            assign p_den = i_den;
            assign p_quo = '0;
        end else begin : g_next
            assign p_rem = r_rem[j-1];
            assign p_den = r_den[j-1];
            assign p_quo = r_quo[j-1];
        end

        assign shifted = {{(64-DEN_W){1'b0}}, p_den} << K;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j] <= p_den;
                if (p_rem >= shifted) begin
                    r_rem[j] <= p_rem - shifted;
                    r_quo[j] <= p_quo | (QUO_W'(1) << K);
                end else begin
                    r_rem[j] <= p_rem;
                    r_quo[j] <= p_quo;
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// File: design/sphere_sphere_contact_unit.sv
// Sphere-sphere contact unit. Takes one sphere pair per cycle and returns one
// result word per pair, in order, through 4 front stages, 32 square-root
// stages (one root bit each), 4 operand stages, 31 divider stages (one
// quotient bit each, six lanes in parallel) and the output register.
// Sustained rate is one word per cycle; a stall on the master side holds the
// whole pipeline. The user must write the coincidence threshold register
// through i_cfg_we/i_cfg_wdata only while idle; the block does not enforce it.
// Depends on scc_pkg, scc_front, scc_root, scc_prep and scc_div.
module sphere_sphere_contact_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [15:0]                 i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, zero pad
    input  logic [scc_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // hit, contact_x, contact_y, contact_z, normal_x, normal_y, normal_z, depth
    output logic [scc_pkg::OUT_W-1:0]   m_axis_tdata
);
    import scc_pkg::*;

    logic                   en;
    logic [15:0]            r_nz;
    logic [2:0][31:0]       in_a, in_b;
    logic                   f_vld, rt_vld, p_vld;
    logic [63:0]            f_sum;
    t_side_front            f_side, rt_side;
    logic [ROOT_W-1:0]      rt_dist;
    t_side_div              p_side;
    logic [2:0][NUM_W-1:0]  p_num_n, p_num_o;
    logic [DEN_W-1:0]       p_den_n, p_den_o;
    logic [2:0][QUO_W-1:0]  q_n, q_o;
    t_side_div              r_dside [0:QUO_W-1];
    logic [QUO_W-1:0]       r_dvld;
    t_side_div              tail;
    logic [2:0][15:0]       n_norm;
    logic [2:0][31:0]       n_cont;
    logic [OUT_W-1:0]       n_tdata;
    logic [OUT_W-1:0]       r_tdata;
    logic                   r_tvalid;

    // global advance: output register empty or being taken
    assign en            = !r_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz <= NZ_RESET;
        end else if (i_cfg_we) begin
            r_nz <= i_cfg_wdata;
        end
    end

    assign in_a = {s_axis_tdata[95:64], s_axis_tdata[63:32], s_axis_tdata[31:0]};
    assign in_b = {s_axis_tdata[221:190], s_axis_tdata[189:158], s_axis_tdata[157:126]};

    scc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_a     (in_a),
        .i_b     (in_b),
        .i_ra    (s_axis_tdata[125:96]),
        .i_rb    (s_axis_tdata[251:222]),
        .o_valid (f_vld),
        .o_sum   (f_sum),
        .o_side  (f_side)
    );

    scc_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_vld),
        .i_sum   (f_sum),
        .i_side  (f_side),
        .o_valid (rt_vld),
        .o_dist  (rt_dist),
        .o_side  (rt_side)
    );

    scc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_vld),
        .i_dist  (rt_dist),
        .i_side  (rt_side),
        .i_nz    (r_nz),
        .o_valid (p_vld),
        .o_side  (p_side),
        .o_num_n (p_num_n),
        .o_num_o (p_num_o),
        .o_den_n (p_den_n),
        .o_den_o (p_den_o)
    );

    // six divider lanes: normal and contact offset per axis
    for (genvar i = 0; i < 3; i++) begin : g_lane
        scc_div u_div_n (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (p_num_n[i]),
            .i_den (p_den_n),
            .o_quo (q_n[i])
        );
        scc_div u_div_o (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (p_num_o[i]),
            .i_den (p_den_o),
            .o_quo (q_o[i])
        );
    end

    // item data kept in step with the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
        end else if (en) begin
            r_dvld <= {r_dvld[QUO_W-2:0], p_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dside[0] <= p_side;
            for (int j = 1; j < QUO_W; j++) begin
                r_dside[j] <= r_dside[j-1];
            end
        end
    end

    assign tail = r_dside[QUO_W-1];

    // signs, contact sum with saturation, result select
    always_comb begin
        logic [33:0] off;
        logic [33:0] sum;
        for (int i = 0; i < 3; i++) begin
            n_norm[i] = tail.dneg[i] ? (~q_n[i][15:0] + 16'd1) : q_n[i][15:0];
            off = (tail.dneg[i] ^ tail.fneg) ? (~{3'b000, q_o[i]} + 34'd1)
                                             : {3'b000, q_o[i]};
            sum = {{2{tail.a[i][31]}}, tail.a[i]} + off;
            if (!sum[33] && (sum[32:31] != 2'b00)) begin
                n_cont[i] = 32'h7FFF_FFFF;
            end else if (sum[33] && (sum[32:31] != 2'b11)) begin
                n_cont[i] = 32'h8000_0000;
            end else begin
                n_cont[i] = sum[31:0];
            end
        end
        if (!tail.hit) begin
            n_tdata = '0;
        end else if (tail.coinc) begin
            n_tdata = {tail.pen, 16'd0, 16'd0, NORMAL_ONE,
                       tail.a[2], tail.a[1], tail.a[0], 1'b1};
        end else begin
            n_tdata = {tail.pen, n_norm[2], n_norm[1], n_norm[0],
                       n_cont[2], n_cont[1], n_cont[0], 1'b1};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (en) begin
            r_tvalid <= r_dvld[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdata <= n_tdata;
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;

`ifndef SYNTH
    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tvalid && !r_tdata[0]) |-> (r_tdata[OUT_W-1:1] == '0))
        else $error("miss word with nonzero fields");

    // normal components stay within one in Q1.14
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tvalid |-> ((r_tdata[112:97] <= NORMAL_ONE || r_tdata[112:97] >= 16'hC000) &&
                      (r_tdata[128:113] <= NORMAL_ONE || r_tdata[128:113] >= 16'hC000) &&
                      (r_tdata[144:129] <= NORMAL_ONE || r_tdata[144:129] >= 16'hC000)))
        else $error("normal out of range");

    // nothing leaves the pipeline right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
